>>> src/actr_pkg.sv
// Shared types, constants and AES helper functions for the counter-mode keystream engine.
package actr_pkg;

    localparam int BlockW  = 128;
    localparam int HalfW   = 64;
    localparam int CountW  = 5;
    localparam int Rounds  = 10;
    localparam int RoundW  = 4;

    // Input command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Configuration register indexes.
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    // One classified beat passed from the front end to the cipher pipeline.
    typedef struct packed {
        logic [BlockW-1:0] ctr_block;
        logic [BlockW-1:0] data;
        logic [CountW-1:0] nbytes;
    } job_t;

    // Forward S-box.
    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Round constant for key round r (1..10).
    function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
            4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
            4'd9: v = 8'h1b; 4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Next round key from the previous one; byte i sits at bits [8i+7:8i].
    function automatic logic [BlockW-1:0] next_key(input logic [BlockW-1:0] k,
                                                   input logic [RoundW-1:0] r);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
              sbox(k[111:104]) ^ rcon(r)};
        w0 = k[31:0] ^ t;
        w1 = k[63:32] ^ w0;
        w2 = k[95:64] ^ w1;
        w3 = k[127:96] ^ w2;
        return {w3, w2, w1, w0};
    endfunction

    // One cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
    function automatic logic [BlockW-1:0] aes_round(input logic [BlockW-1:0] s,
                                                    input logic [BlockW-1:0] k,
                                                    input logic last);
        logic [BlockW-1:0] t;
        logic [BlockW-1:0] m;
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[8*(4*c+i) +: 8] = sbox(s[8*(4*((c+i)%4)+i) +: 8]);
            end
        end
        m = t;
        for (int c = 0; c < 4; c++) begin
            a0  = t[8*(4*c)   +: 8];
            a1  = t[8*(4*c+1) +: 8];
            a2  = t[8*(4*c+2) +: 8];
            a3  = t[8*(4*c+3) +: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            m[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            m[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            m[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            m[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return (last ? t : m) ^ k;
    endfunction

endpackage

>>> src/actr_front.sv
// Front end: takes input beats, keeps IV and counter, and emits counter blocks for data beats.
module actr_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_take,
    input  logic                       command,
    input  logic [actr_pkg::HalfW-1:0] data_low,
    input  logic [actr_pkg::HalfW-1:0] data_high,
    input  logic [actr_pkg::CountW-1:0] valid_bytes,
    output logic                       job_push,
    output actr_pkg::job_t             job
);

    logic [actr_pkg::HalfW-1:0] iv_low_reg, iv_high_reg, ctr_reg;

    // A start beat reloads the IV; a data beat uses it and bumps the counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_low_reg  <= '0;
            iv_high_reg <= '0;
            ctr_reg     <= '0;
        end
        else if (in_take)
        begin
            if (command == actr_pkg::CMD_START)
            begin
                iv_low_reg  <= data_low;
                iv_high_reg <= data_high;
                ctr_reg     <= '0;
            end
            else
            begin
                ctr_reg <= ctr_reg + 64'd1;
            end
        end
    end

    assign job_push      = in_take && (command == actr_pkg::CMD_DATA);
    assign job.ctr_block = {iv_high_reg, iv_low_reg ^ ctr_reg};
    assign job.data      = {data_high, data_low};
    assign job.nbytes    = valid_bytes;

endmodule

>>> src/actr_fifo.sv
// Small queue that decouples the front end from the cipher pipeline.
module actr_fifo #(
    parameter int Depth = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  actr_pkg::job_t push_data,
    input  logic           pop,
    output logic           not_empty,
    output logic           full,
    output actr_pkg::job_t pop_data
);

    localparam int AW = $clog2(Depth);

    actr_pkg::job_t mem_reg [Depth];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == (AW+1)'(Depth));
    assign pop_data  = mem_reg[rd_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(Depth-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(Depth-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

>>> src/actr_core.sv
// Back end: unrolled AES-128 round pipeline, keystream XOR, masking and output register.
module actr_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [actr_pkg::BlockW-1:0] round_key [actr_pkg::Rounds+1],
    input  logic                        job_valid,
    input  actr_pkg::job_t              job,
    output logic                        job_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [actr_pkg::HalfW-1:0]  out_low,
    output logic [actr_pkg::HalfW-1:0]  out_high,
    output logic [actr_pkg::CountW-1:0] out_bytes
);

    localparam int NS = actr_pkg::Rounds;

    logic [actr_pkg::BlockW-1:0] st_reg   [NS+1];
    logic [actr_pkg::BlockW-1:0] dat_reg  [NS+1];
    logic [actr_pkg::CountW-1:0] cnt_reg  [NS+1];
    logic                        vld_reg  [NS+1];
    logic                        adv;

    logic [actr_pkg::BlockW-1:0] res;
    logic [actr_pkg::BlockW-1:0] mask;
    logic [actr_pkg::BlockW-1:0] res_reg;
    logic [actr_pkg::CountW-1:0] bytes_reg;
    logic                        ovld_reg;

    // The whole pipe moves when the output slot is free or being drained.
    assign adv     = !ovld_reg || !out_stall;
    assign job_pop = adv && job_valid;

    // Stage 0 takes the initial AddRoundKey; stages 1..10 run one round each.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= job_valid;
            for (int s = 1; s <= NS; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0]  <= job.ctr_block ^ round_key[0];
            dat_reg[0] <= job.data;
            cnt_reg[0] <= job.nbytes;
            for (int s = 1; s <= NS; s++)
            begin
                st_reg[s]  <= actr_pkg::aes_round(st_reg[s-1], round_key[s], s == NS);
                dat_reg[s] <= dat_reg[s-1];
                cnt_reg[s] <= cnt_reg[s-1];
            end
        end
    end

    // Byte mask from the valid count, counts above sixteen keep all bytes.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            mask[8*i +: 8] = (cnt_reg[NS] > actr_pkg::CountW'(i)) ? 8'hff : 8'h00;
        end
        res = (st_reg[NS] ^ dat_reg[NS]) & mask;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (adv)
        begin
            ovld_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg   <= res;
            bytes_reg <= cnt_reg[NS];
        end
    end

    assign out_valid = ovld_reg;
    assign out_low   = res_reg[63:0];
    assign out_high  = res_reg[127:64];
    assign out_bytes = bytes_reg;

endmodule

>>> src/actr_keys.sv
// Key registers and round-key expansion, one round key per cycle after reset and after each write.
module actr_keys (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [actr_pkg::HalfW-1:0]  cfg_data,
    output logic [actr_pkg::BlockW-1:0] round_key [actr_pkg::Rounds+1],
    output logic                        busy
);

    logic [actr_pkg::BlockW-1:0] key_reg;
    logic [actr_pkg::BlockW-1:0] rk_reg [1:actr_pkg::Rounds];
    logic [actr_pkg::RoundW-1:0] step_reg;
    logic                        run_reg;
    logic                        hit;

    assign hit  = cfg_write && (cfg_index[1] == 1'b0);
    assign busy = run_reg;

    // A write loads round key 0; later keys follow one per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            step_reg <= 4'd1;
            run_reg  <= 1'b1;
        end
        else if (hit)
        begin
            if (cfg_index[0] == actr_pkg::REG_KEY_LOW)
            begin
                key_reg[63:0] <= cfg_data;
            end
            else
            begin
                key_reg[127:64] <= cfg_data;
            end
            step_reg <= 4'd1;
            run_reg  <= 1'b1;
        end
        else if (run_reg)
        begin
            step_reg <= step_reg + 4'd1;
            if (step_reg == actr_pkg::RoundW'(actr_pkg::Rounds))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 1; r <= actr_pkg::Rounds; r++)
        begin
            if (run_reg && !hit && step_reg == actr_pkg::RoundW'(r))
            begin
                rk_reg[r] <= actr_pkg::next_key(round_key[r-1], actr_pkg::RoundW'(r));
            end
        end
    end

    // Round key 0 is the key itself; the rest come from the expansion registers.
    always_comb
    begin
        round_key[0] = key_reg;
        for (int r = 1; r <= actr_pkg::Rounds; r++)
        begin
            round_key[r] = rk_reg[r];
        end
    end

endmodule

>>> src/aes128_counter_keystream_top.sv
// Top level of the AES-128 counter-mode keystream engine.
// Accepts one 128-bit beat per cycle while in_stall is low; each data beat leaves as
// a result beat through the queue and an unrolled ten-round pipeline (one AES round per
// stage, plus a first key-add stage and an output register). A start beat loads the IV,
// clears the block counter and makes no result. After reset and after each key register
// write, the round keys are expanded one per cycle, during which input is stalled.
module aes128_counter_keystream_top #(
    parameter int QueueDepth = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [63:0] data_low,
    input  logic [63:0] data_high,
    input  logic [4:0]  valid_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_low,
    output logic [63:0] out_high,
    output logic [4:0]  out_bytes
);

    logic [actr_pkg::BlockW-1:0] round_key [actr_pkg::Rounds+1];
    logic           key_busy;
    logic           in_take;
    logic           job_push, job_pop, q_valid, q_full;
    actr_pkg::job_t job_in, job_out;

    // Input is held off while keys expand or the queue is full.
    assign in_stall = key_busy || q_full;
    assign in_take  = in_valid && !in_stall;

    actr_keys u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .round_key (round_key),
        .busy      (key_busy)
    );

    actr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_take     (in_take),
        .command     (command),
        .data_low    (data_low),
        .data_high   (data_high),
        .valid_bytes (valid_bytes),
        .job_push    (job_push),
        .job         (job_in)
    );

    actr_fifo #(.Depth(QueueDepth)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .not_empty (q_valid),
        .full      (q_full),
        .pop_data  (job_out)
    );

    actr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .round_key (round_key),
        .job_valid (q_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_low   (out_low),
        .out_high  (out_high),
        .out_bytes (out_bytes)
    );

endmodule

>>> src/actr_checker.sv
// Port-level checker for the keystream engine, bound to the top level.
module actr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] out_low,
    input logic [63:0] out_high,
    input logic [4:0]  out_bytes
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_low) && $stable(out_high)
        && $stable(out_bytes))
        else $error("result beat changed under stall");

    // A zero byte count leaves an all-zero block.
    a_zero_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_bytes == 5'd0 |-> out_low == 64'd0 && out_high == 64'd0)
        else $error("unmasked bytes with zero count");

    // Short blocks zero the whole high half when eight bytes or fewer are valid.
    a_short_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_bytes <= 5'd8 |-> out_high == 64'd0)
        else $error("high half not masked");

    // No result can appear the cycle after reset.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind aes128_counter_keystream_top actr_checker u_actr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_low   (out_low),
    .out_high  (out_high),
    .out_bytes (out_bytes)
);
